// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Every macro assumes clk_i and rst_ni are visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GOI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("odometry check failed");

// Expression must never be true outside reset.
`define GOI_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("odometry forbidden condition seen");

`endif

// ===== design/goi_pkg.sv =====
// Shared types, constants and the arctangent table for the odometry integrator.
// No dependencies; used by the controller, the datapath and the top level.
package goi_pkg;

  // CORDIC iteration count and index width
  localparam int CordicStepsDef = 24;
  localparam int IdxW           = 5;

  // Field widths
  localparam int VelW  = 24;
  localparam int RateW = 24;
  localparam int DtW   = 20;
  localparam int ThrW  = 23;
  localparam int PosW  = 32;
  localparam int AngW  = 32;

  // Stream payload widths
  localparam int SDataW = 96;
  localparam int MDataW = 144;

  // Internal arithmetic widths
  localparam int CordW = 34;
  localparam int MulAW = 33;
  localparam int MulBW = 25;
  localparam int MulPW = MulAW + MulBW;
  localparam int ProdW = 64;

  // Constants
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic        [20:0]      RadToBam  = 21'd667544;
  localparam logic        [ThrW-1:0]  ThrReset  = 23'd1966;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROT,
    OP_MUL_VC,
    OP_MUL_VS,
    OP_RND30,
    OP_MUL_TDT,
    OP_RND20,
    OP_ADD_X,
    OP_ADD_Y,
    OP_MUL_RDT,
    OP_MUL_KLO,
    OP_MUL_KHI,
    OP_ADD_KHI,
    OP_RND26,
    OP_ADD_ANG,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [AngW-1:0] atan_bam(input logic [IdxW-1:0] i);
    logic [AngW-1:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/goi_ctrl.sv =====
// Sequencer for the odometry integrator: accepts one update, steps the datapath.
// Depends on goi_pkg for the command and status types.
module goi_ctrl
  import goi_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam int IterW = $clog2(CORDIC_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_ROT, S_MVC, S_RX1, S_MTX, S_RX2, S_ADDX,
    S_MVS, S_RY1, S_MTY, S_RY2, S_ADDY,
    S_MRD, S_MKL, S_MKH, S_AKH, S_RTH, S_ADDT, S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             last_iter;

  assign last_iter  = (iter_q == IterW'(CORDIC_STEPS - 1));
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = IdxW'(iter_q);
    case (state_q)
      S_IDLE: begin
        iter_d = '0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_ROT;
        end
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        iter_d   = iter_q + 1'b1;
        if (last_iter) begin
          state_d = S_MVC;
        end
      end
      S_MVC:  begin cmd_o.op = OP_MUL_VC;  state_d = S_RX1;  end
      S_RX1:  begin cmd_o.op = OP_RND30;   state_d = S_MTX;  end
      S_MTX:  begin cmd_o.op = OP_MUL_TDT; state_d = S_RX2;  end
      S_RX2:  begin cmd_o.op = OP_RND20;   state_d = S_ADDX; end
      S_ADDX: begin cmd_o.op = OP_ADD_X;   state_d = S_MVS;  end
      S_MVS:  begin cmd_o.op = OP_MUL_VS;  state_d = S_RY1;  end
      S_RY1:  begin cmd_o.op = OP_RND30;   state_d = S_MTY;  end
      S_MTY:  begin cmd_o.op = OP_MUL_TDT; state_d = S_RY2;  end
      S_RY2:  begin cmd_o.op = OP_RND20;   state_d = S_ADDY; end
      S_ADDY: begin cmd_o.op = OP_ADD_Y;   state_d = S_MRD;  end
      S_MRD:  begin cmd_o.op = OP_MUL_RDT; state_d = S_MKL;  end
      S_MKL:  begin cmd_o.op = OP_MUL_KLO; state_d = S_MKH;  end
      S_MKH:  begin cmd_o.op = OP_MUL_KHI; state_d = S_AKH;  end
      S_AKH:  begin cmd_o.op = OP_ADD_KHI; state_d = S_RTH;  end
      S_RTH:  begin cmd_o.op = OP_RND26;   state_d = S_ADDT; end
      S_ADDT: begin cmd_o.op = OP_ADD_ANG; state_d = S_DONE; end
      S_DONE: begin
        // wait until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ===== design/goi_dpath.sv =====
// Datapath: input capture, shared CORDIC rotator, shared multiplier, rounding,
// saturating accumulators and the output register. Depends on goi_pkg.
module goi_dpath
  import goi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [SDataW-1:0] in_data_i,
  input  logic              cfg_valid_i,
  input  logic [ThrW-1:0]   cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MDataW-1:0] out_data_o,
  output logic              out_user_o
);

  // Input item registers
  logic signed [VelW:0]     vel_q, vel_d;    // speed, negated when the angle was folded
  logic signed [VelW-1:0]   echo_q, echo_d;
  logic signed [RateW-1:0]  rate_q, rate_d;
  logic        [DtW-1:0]    dt_q, dt_d;
  logic                     gyro_q, gyro_d;

  // CORDIC registers
  logic signed [CordW-1:0]  cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

  // Product, scratch and split-multiply registers
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic        [41:0]       lo_q, lo_d;
  logic signed [21:0]       hold_q, hold_d;
  logic signed [31:0]       t_q, t_d;

  // Architectural state
  logic signed [PosW-1:0]   xacc_q, xacc_d, yacc_q, yacc_d;
  logic        [AngW-1:0]   ang_q, ang_d;
  logic        [ThrW-1:0]   thr_q;

  // Output register
  logic                     ovalid_q, ovalid_d;
  logic        [MDataW-1:0] odata_q, odata_d;
  logic                     ouser_q, ouser_d;

  // Shared multiplier
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulPW-1:0]  mul_p;

  // Rounding unit
  logic        [5:0]        rnd_sh;
  logic signed [ProdW-1:0]  rnd_half, rnd_sum, rnd_res;

  // Load helpers
  logic signed [VelW-1:0]   in_v, in_wr, in_gr;
  logic signed [VelW:0]     v25, gr25, mag;
  logic signed [AngW-1:0]   z32;
  logic                     flip;
  logic        [AngW-1:0]   zfold;

  // CORDIC helpers
  logic signed [CordW-1:0]  xs, ys, at;

  // Saturating adds
  logic        [PosW:0]     sx, sy;

  assign stat_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o     = ovalid_q;
  assign out_data_o      = odata_q;
  assign out_user_o      = ouser_q;

  // Load decode: field split, rate choice, heading fold
  assign in_v  = $signed(in_data_i[23:0]);
  assign in_wr = $signed(in_data_i[47:24]);
  assign in_gr = $signed(in_data_i[71:48]);
  assign v25   = {in_v[VelW-1], in_v};
  assign gr25  = {in_gr[VelW-1], in_gr};
  assign mag   = gr25[VelW] ? -gr25 : gr25;
  assign z32   = $signed(ang_q);
  assign flip  = (z32 > 32'sd1073741824) || (z32 < -32'sd1073741824);
  assign zfold = flip ? (ang_q + 32'h8000_0000) : ang_q;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_VC: begin
        mul_a = cx_q[MulAW-1:0];
        mul_b = vel_q;
      end
      OP_MUL_VS: begin
        mul_a = cy_q[MulAW-1:0];
        mul_b = vel_q;
      end
      OP_MUL_TDT: begin
        mul_a = {t_q[31], t_q};
        mul_b = $signed({5'b0, dt_q});
      end
      OP_MUL_RDT: begin
        mul_a = {{(MulAW-RateW){rate_q[RateW-1]}}, rate_q};
        mul_b = $signed({5'b0, dt_q});
      end
      OP_MUL_KLO: begin
        mul_a = $signed({11'b0, prod_q[21:0]});
        mul_b = $signed({4'b0, RadToBam});
      end
      OP_MUL_KHI: begin
        mul_a = {{11{hold_q[21]}}, hold_q};
        mul_b = $signed({4'b0, RadToBam});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round to nearest, ties away from zero: (v + half - sign) >>> sh
  always_comb begin
    case (cmd_i.op)
      OP_RND30: rnd_sh = 6'd30;
      OP_RND20: rnd_sh = 6'd20;
      OP_RND26: rnd_sh = 6'd26;
      default:  rnd_sh = 6'd1;
    endcase
  end

  assign rnd_half = 64'sd1 <<< (rnd_sh - 6'd1);
  assign rnd_sum  = prod_q + rnd_half - $signed({63'b0, prod_q[ProdW-1]});
  assign rnd_res  = rnd_sum >>> rnd_sh;

  // One CORDIC micro-rotation
  assign xs = cx_q >>> cmd_i.idx;
  assign ys = cy_q >>> cmd_i.idx;
  assign at = $signed({2'b0, atan_bam(cmd_i.idx)});

  // Position sums with one guard bit
  assign sx = {xacc_q[PosW-1], xacc_q} + {t_q[31], t_q};
  assign sy = {yacc_q[PosW-1], yacc_q} + {t_q[31], t_q};

  // Next-state logic
  always_comb begin
    vel_d    = vel_q;
    echo_d   = echo_q;
    rate_d   = rate_q;
    dt_d     = dt_q;
    gyro_d   = gyro_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    prod_d   = prod_q;
    lo_d     = lo_q;
    hold_d   = hold_q;
    t_d      = t_q;
    xacc_d   = xacc_q;
    yacc_d   = yacc_q;
    ang_d    = ang_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    ovalid_d = ovalid_q && !out_ready_i;
    case (cmd_i.op)
      OP_LOAD: begin
        gyro_d = (mag > $signed({2'b0, thr_q}));
        rate_d = (mag > $signed({2'b0, thr_q})) ? in_gr : in_wr;
        echo_d = in_v;
        dt_d   = in_data_i[91:72];
        vel_d  = flip ? -v25 : v25;
        cx_d   = GainQ30;
        cy_d   = '0;
        cz_d   = {{(CordW-AngW){zfold[AngW-1]}}, zfold};
      end
      OP_ROT: begin
        if (!cz_q[CordW-1]) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + at;
        end
      end
      OP_MUL_VC, OP_MUL_VS, OP_MUL_TDT, OP_MUL_RDT: begin
        prod_d = {{(ProdW-MulPW){mul_p[MulPW-1]}}, mul_p};
      end
      OP_MUL_KLO: begin
        prod_d = {{(ProdW-MulPW){mul_p[MulPW-1]}}, mul_p};
        hold_d = prod_q[43:22];
      end
      OP_MUL_KHI: begin
        prod_d = {{(ProdW-MulPW){mul_p[MulPW-1]}}, mul_p};
        lo_d   = prod_q[41:0];
      end
      OP_ADD_KHI: begin
        prod_d = (prod_q <<< 22) + $signed({22'b0, lo_q});
      end
      OP_RND30, OP_RND20, OP_RND26: begin
        t_d = rnd_res[31:0];
      end
      OP_ADD_X: begin
        if (sx[PosW] != sx[PosW-1]) begin
          xacc_d = sx[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        end else begin
          xacc_d = sx[PosW-1:0];
        end
      end
      OP_ADD_Y: begin
        if (sy[PosW] != sy[PosW-1]) begin
          yacc_d = sy[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        end else begin
          yacc_d = sy[PosW-1:0];
        end
      end
      OP_ADD_ANG: begin
        ang_d = ang_q + t_q;
      end
      OP_OUT: begin
        odata_d  = {echo_q, rate_q, ang_q, yacc_q, xacc_q};
        ouser_d  = gyro_q;
        ovalid_d = 1'b1;
      end
      default: begin
        ovalid_d = ovalid_q && !out_ready_i;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xacc_q   <= '0;
      yacc_q   <= '0;
      ang_q    <= '0;
      thr_q    <= ThrReset;
      ovalid_q <= 1'b0;
    end else begin
      xacc_q   <= xacc_d;
      yacc_q   <= yacc_d;
      ang_q    <= ang_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    vel_q   <= vel_d;
    echo_q  <= echo_d;
    rate_q  <= rate_d;
    dt_q    <= dt_d;
    gyro_q  <= gyro_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    prod_q  <= prod_d;
    lo_q    <= lo_d;
    hold_q  <= hold_d;
    t_q     <= t_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

endmodule

// ===== design/gyro_assisted_odometry_integrator_top.sv =====
// Top level of the gyro-assisted odometry integrator.
// Depends on goi_pkg, goi_ctrl and goi_dpath.

// Dead-reckoning odometry for a differential drive. Each transfer on the slave
// stream is one update (speed, wheel and gyro yaw rates, elapsed time); the
// gyro rate is used when its magnitude is strictly above the drift threshold.
// The speed is rotated by the current heading (CORDIC sin/cos), scaled by the
// elapsed time and added to saturating x/y positions, then the heading is
// advanced; one result transfer follows each update. An update is handled by the
// single shared CORDIC rotator, one step per cycle, followed by seven passes
// through one shared 33x25 multiplier with rounding and accumulate steps between
// them. One update is in flight at a time; a finished result waits in the output
// register while the next update is accepted. The threshold port is always ready
// and must only be written while the block is idle.
module gyro_assisted_odometry_integrator_top
  import goi_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // drift threshold write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ThrW-1:0]   cfg_data_i,
  // update stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // lin_vel[23:0], wheel_yaw_rate[47:24], imu_yaw_rate[71:48], elapsed[91:72]
  input  logic [SDataW-1:0] s_axis_tdata,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[95:64], yaw_rate_used[119:96],
  // speed_echo[143:120]
  output logic [MDataW-1:0] m_axis_tdata,
  // from_gyro[0]
  output logic              m_axis_tuser
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  goi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  goi_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== design/goi_checker.sv =====
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on goi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module goi_checker
  import goi_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  // a stalled result stays put
  `GOI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one update in flight: no back-to-back input transfers
  `GOI_ASSERT(a_in_single, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // valid stays up after a result transfer only when a fresh result was loaded
  `GOI_ASSERT(a_out_reload, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid || s_axis_tready)

  // a result cannot appear in the cycle right after an input transfer
  `GOI_ASSERT(a_no_early_out, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)

  // threshold channel never back-pressures
  `GOI_NEVER(a_cfg_ready, cfg_valid_i && !cfg_ready_o)

endmodule

bind gyro_assisted_odometry_integrator_top goi_checker u_goi_checker (.*);

// ===== sim/tb_gyro_assisted_odometry_integrator_top.sv =====
// Self-checking testbench for gyro_assisted_odometry_integrator_top.
// Depends on goi_pkg and the design sources; each result transfer is checked against
// an odometry predictor or typed-in result, with random idling on both streams.
module tb_gyro_assisted_odometry_integrator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import goi_pkg::*;

  // CORDIC depth of the predictor (capped at 32 steps); the instance is uncapped
  localparam int     Steps        = (CordicStepsDef > 32) ? 32 : CordicStepsDef;
  localparam longint CosGain      = 652032874;
  localparam longint BamPerRad    = 667544;
  localparam longint PosHi        = 64'sh0000_0000_7FFF_FFFF;
  localparam longint PosLo        = -64'sh0000_0000_8000_0000;
  localparam int     SettleCycles = CordicStepsDef + 24;

  localparam logic signed [VelW-1:0] VelMax     = {1'b0, {(VelW-1){1'b1}}};
  localparam logic signed [VelW-1:0] VelMin     = {1'b1, {(VelW-1){1'b0}}};
  localparam logic        [DtW-1:0]  DtMax      = '1;
  localparam logic        [ThrW-1:0] ThrMax     = '1;
  localparam logic        [ThrW-1:0] ThrDefault = 23'd1966;

  typedef struct packed {
    logic signed [VelW-1:0]  lin_vel;
    logic signed [RateW-1:0] wheel_rate;
    logic signed [RateW-1:0] imu_rate;
    logic        [DtW-1:0]   elapsed;
  } upd_t;

  typedef struct packed {
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic        [AngW-1:0]  heading;
    logic signed [RateW-1:0] rate_used;
    logic signed [VelW-1:0]  speed;
    logic                    gyro;
  } odo_t;

  // one directed row: update fields, then the typed-in result where known
  typedef struct packed {
    logic signed [VelW-1:0]  lin;
    logic signed [RateW-1:0] wheel;
    logic signed [RateW-1:0] imu;
    logic        [DtW-1:0]   dt;
    logic                    known;
    logic signed [PosW-1:0]  x;
    logic signed [PosW-1:0]  y;
    logic        [AngW-1:0]  hd;
    logic signed [RateW-1:0] rate;
    logic                    gyro;
  } dir_row_t;

  typedef enum {MIX_FIELDS, NEAR_THRESHOLD, CRUISE} drive_style_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ThrW-1:0]   cfg_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [MDataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  // predictor state
  logic        [ThrW-1:0] thr_model;
  logic signed [PosW-1:0] x_model;
  logic signed [PosW-1:0] y_model;
  logic        [AngW-1:0] ang_model;

  odo_t pending_odo [$];
  int   mismatches   = 0;
  int   updates_sent = 0;
  int   results_seen = 0;
  int   cfg_writes   = 0;
  bit   no_idle      = 1'b0;

  // atan(2^-i) in binary-angle units
  logic [31:0] arctan_bam [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  gyro_assisted_odometry_integrator_top #(
    .CORDIC_STEPS(CordicStepsDef)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // round to nearest, ties away from zero
  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // cos/sin of the heading in Q2.30; fold to +-1/4 turn, then rotate
  function automatic void heading_sincos(input logic [AngW-1:0] ang,
                                         output longint c, output longint s);
    logic [AngW-1:0] a;
    longint z, x, y, t;
    bit flip;
    a    = ang;
    flip = 1'b0;
    z    = longint'($signed(a));
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      a    = a + 32'h8000_0000;
      z    = longint'($signed(a));
      flip = 1'b1;
    end
    x = CosGain;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(arctan_bam[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(arctan_bam[i]);
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // one odometry update: move along the old heading, then turn
  function automatic odo_t advance_odometry(upd_t u);
    longint v, wr, gr, dt, mag, rate, c, s, dx, dy, sx, sy, dth;
    bit gyro;
    odo_t r;
    v    = longint'(u.lin_vel);
    wr   = longint'(u.wheel_rate);
    gr   = longint'(u.imu_rate);
    dt   = longint'(u.elapsed);
    mag  = (gr < 0) ? -gr : gr;
    gyro = mag > longint'(thr_model);
    rate = gyro ? gr : wr;
    heading_sincos(ang_model, c, s);
    dx = round_shift(round_shift(v * c, 30) * dt, 20);
    dy = round_shift(round_shift(v * s, 30) * dt, 20);
    sx = longint'(x_model) + dx;
    sy = longint'(y_model) + dy;
    if (sx > PosHi) sx = PosHi;
    if (sx < PosLo) sx = PosLo;
    if (sy > PosHi) sy = PosHi;
    if (sy < PosLo) sy = PosLo;
    x_model   = sx[PosW-1:0];
    y_model   = sy[PosW-1:0];
    dth       = round_shift(rate * dt * BamPerRad, 26);
    ang_model = ang_model + dth[AngW-1:0];
    r.pos_x     = x_model;
    r.pos_y     = y_model;
    r.heading   = ang_model;
    r.rate_used = rate[RateW-1:0];
    r.speed     = u.lin_vel;
    r.gyro      = gyro;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int draw_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic upd_t make_update(drive_style_e style, bit go_back);
    upd_t u;
    longint near;
    int unsigned pick;
    u.lin_vel    = VelW'($urandom);
    u.wheel_rate = RateW'($urandom);
    u.imu_rate   = RateW'($urandom);
    u.elapsed    = DtW'($urandom);
    case (style)
      MIX_FIELDS: begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       u.lin_vel    = VelMax;
          1:       u.lin_vel    = VelMin;
          2:       u.wheel_rate = VelMax;
          3:       u.wheel_rate = VelMin;
          4:       u.imu_rate   = VelMax;
          5:       u.imu_rate   = VelMin;
          6:       u.elapsed    = DtMax;
          7:       u.elapsed    = '0;
          8:       u.elapsed    = DtW'($urandom_range(0, 255));
          9:       u.imu_rate   = '0;
          default: ;
        endcase
      end
      NEAR_THRESHOLD: begin
        // gyro magnitude within two counts of the threshold
        near = longint'(thr_model) + longint'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 8388608) near = 8388608;
        if ($urandom_range(0, 1) == 1) near = -near;
        u.imu_rate = near[RateW-1:0];
      end
      CRUISE: begin
        // near full speed and dt, heading nearly held: drives a position into its limit
        u.lin_vel = go_back ? VelW'(VelMin + $urandom_range(0, 255))
                            : VelW'(VelMax - $urandom_range(0, 255));
        u.wheel_rate = ($urandom_range(0, 7) == 0) ? RateW'($urandom_range(0, 3))
                                                   : RateW'(0);
        u.imu_rate   = RateW'($urandom_range(0, thr_model));
        if ($urandom_range(0, 1) == 1) u.imu_rate = -u.imu_rate;
        u.elapsed = DtW'(DtMax - $urandom_range(0, 4095));
      end
      default: ;
    endcase
    return u;
  endfunction

  task automatic send_update(input upd_t u, input bit typed, input odo_t typed_res);
    int gap;
    odo_t pred;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(SDataW-VelW-2*RateW-DtW){1'b0}},
                      u.elapsed, u.imu_rate, u.wheel_rate, u.lin_vel};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_odometry(u);
    pending_odo.push_back(typed ? typed_res : pred);
    updates_sent++;
  endtask

  // hold the sender until every pending result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_odo.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = val;
    cfg_writes++;
  endtask

  task automatic run_updates(input int count, input drive_style_e style);
    bit go_back;
    odo_t none;
    go_back = 1'($urandom_range(0, 1));
    none    = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      send_update(make_update(style, go_back), 1'b0, none);
    end
  endtask

  task automatic check_odometry(input odo_t got);
    odo_t want;
    if (pending_odo.size() == 0) begin
      $display("%0t: result transfer with nothing pending, got %h", $time, got);
      mismatches++;
    end else begin
      want = pending_odo.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.heading !== want.heading) begin
        $display("%0t: heading expected %h got %h", $time, want.heading, got.heading);
        mismatches++;
      end
      if (got.rate_used !== want.rate_used) begin
        $display("%0t: yaw_rate_used expected %0d got %0d", $time,
                 want.rate_used, got.rate_used);
        mismatches++;
      end
      if (got.speed !== want.speed) begin
        $display("%0t: speed_echo expected %0d got %0d", $time, want.speed, got.speed);
        mismatches++;
      end
      if (got.gyro !== want.gyro) begin
        $display("%0t: from_gyro expected %b got %b", $time, want.gyro, got.gyro);
        mismatches++;
      end
    end
  endtask

  // result side: check each transfer, then pick the next ready level
  initial begin
    odo_t got;
    int stall_left;
    stall_left     = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.pos_x     = m_axis_tdata[31:0];
        got.pos_y     = m_axis_tdata[63:32];
        got.heading   = m_axis_tdata[95:64];
        got.rate_used = m_axis_tdata[119:96];
        got.speed     = m_axis_tdata[143:120];
        got.gyro      = m_axis_tuser;
        check_odometry(got);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = draw_idle();
      end
    end
  end

  // main sequence
  initial begin
    dir_row_t directed [$];
    upd_t u;
    odo_t typed;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    thr_model = ThrDefault;
    x_model   = '0;
    y_model   = '0;
    ang_model = '0;

    // zero elapsed time right after reset: position and heading stay at zero,
    // only the rate selection shows (threshold equality picks the wheel rate)
    directed.push_back('{24'sd0, 24'sd0, 24'sd0, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMax, VelMin, 24'sd1966, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, VelMin, 1'b0});
    directed.push_back('{VelMin, VelMax, 24'sd1967, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, 24'sd1967, 1'b1});
    directed.push_back('{24'sd123, 24'sd5, -24'sd1966, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, 24'sd5, 1'b0});
    directed.push_back('{-24'sd1, 24'sd7, -24'sd1967, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, -24'sd1967, 1'b1});
    directed.push_back('{24'sd0, 24'sd0, VelMin, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, VelMin, 1'b1});
    directed.push_back('{24'sd0, 24'sd0, VelMax, 20'd0,
                         1'b1, 32'sd0, 32'sd0, 32'd0, VelMax, 1'b1});
    // motion rows, checked by the predictor
    directed.push_back('{VelMax, 24'sd0, 24'sd0, DtMax, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMin, 24'sd0, 24'sd0, DtMax, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{24'sd1, 24'sd0, 24'sd0, 20'd1, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{-24'sd1, 24'sd0, 24'sd0, DtMax, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    // roughly a quarter turn, then drive along it
    directed.push_back('{24'sd65536, 24'sd102944, 24'sd0, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMax, 24'sd0, 24'sd0, 20'd524288,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    // past a quarter turn: sin/cos take the half-turn fold
    directed.push_back('{24'sd65536, 24'sd205887, 24'sd0, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMax, 24'sd0, 24'sd0, DtMax, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    // gyro and wheel rate extremes: heading wraps many turns
    directed.push_back('{-24'sd12345, 24'sd0, VelMax, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMin, 24'sd0, VelMin, DtMax, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{24'sd300000, VelMax, 24'sd0, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{24'sd300000, VelMin, 24'sd100, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMax, -24'sd102944, 24'sd1966, DtMax,
                         1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});
    directed.push_back('{VelMin, 24'sd0, 24'sd0, 20'd1, 1'b0, 32'sd0, 32'sd0, 32'd0, 24'sd0, 1'b0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      u     = '{directed[k].lin, directed[k].wheel, directed[k].imu, directed[k].dt};
      typed = '{directed[k].x, directed[k].y, directed[k].hd, directed[k].rate,
                directed[k].lin, directed[k].gyro};
      send_update(u, directed[k].known, typed);
    end

    // random phases over several thresholds, extremes included
    write_threshold('0);
    run_updates(120, MIX_FIELDS);
    write_threshold(ThrMax);
    no_idle = 1'b1;
    run_updates(40, MIX_FIELDS);
    no_idle = 1'b0;
    run_updates(60, MIX_FIELDS);
    write_threshold(ThrW'($urandom_range(1, ThrMax - 1)));
    run_updates(120, NEAR_THRESHOLD);
    write_threshold(ThrDefault);
    run_updates(380, CRUISE);
    write_threshold(ThrW'($urandom_range(0, ThrMax)));
    run_updates(60, NEAR_THRESHOLD);
    run_updates(120, MIX_FIELDS);
    drain_results();

    $display("Covered %0d updates, %0d results, %0d threshold writes: rate selection,",
             updates_sent, results_seen, cfg_writes);
    $display("heading fold and wrap, position saturation, stream stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
